FILE: hdl/cjkb_pkg.sv
// Shared constants and types of the UTF-8 CJK bigram tokenizer.
// No dependencies; every other file of the block but cjkb_ram imports this package.
package cjkb_pkg;

	// Longest CJK run that is buffered before it is flushed early.
	localparam int MAX_RUN = 16;
	// Entries of the run memory and the matching address width.
	localparam int RUN_DEPTH = 16;
	localparam int RUN_AW = $clog2(RUN_DEPTH);
	// Counter width that can hold a full run length.
	localparam int CNT_W = $clog2(MAX_RUN + 1);

	// Payload widths.
	localparam int CODE_W = 16;
	localparam int ASCII_W = 7;
	localparam int BYTE_W = 8;

	// Input command codes.
	localparam logic CMD_TEXT = 1'b0;
	localparam logic CMD_END = 1'b1;

	// Work handed from the byte decoder to the result sequencer for one item:
	// first the buffered run is flushed, then up to two ASCII results follow.
	typedef struct packed {
		logic start;
		logic [CNT_W-1:0] run_n;
		logic [1:0] d_cnt;
		logic [1:0][ASCII_W-1:0] d_char;
		logic [1:0] d_end;
	} job_t;

	// Write port of the run memory.
	typedef struct packed {
		logic en;
		logic [RUN_AW-1:0] addr;
		logic [CODE_W-1:0] data;
	} run_wr_t;

endpackage

FILE: hdl/cjkb_ifs.sv
// Valid/ready channel interfaces of the tokenizer: text input and token output.
// Depends on cjkb_pkg for the payload widths.
interface cjkb_text_if;
	import cjkb_pkg::*;

	logic valid;
	logic ready;
	logic command;
	logic [BYTE_W-1:0] text_byte;

	modport source (output valid, output command, output text_byte, input ready);
	modport sink (input valid, input command, input text_byte, output ready);
endinterface

interface cjkb_token_if;
	import cjkb_pkg::*;

	logic valid;
	logic ready;
	logic [CODE_W-1:0] char_code;
	logic token_end;
	logic last;

	modport source (output valid, output char_code, output token_end, output last,
		input ready);
	modport sink (input valid, input char_code, input token_end, input last,
		output ready);
endinterface

FILE: hdl/cjkb_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module cjkb_ram #(
	parameter int Width = 16,
	parameter int Depth = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem_q [Depth];

	// Write and registered read share the clock.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hdl/cjkb_decode.sv
// Byte decoder of the tokenizer: UTF-8 sequence state, held ASCII character,
// run count and run memory writes. Depends on cjkb_pkg and cjkb_ifs.
module cjkb_decode (
	input logic clk,
	input logic arst_n,
	cjkb_text_if.sink text_ch,
	input logic take_ok,
	output cjkb_pkg::job_t job,
	output cjkb_pkg::run_wr_t run_wr
);
	import cjkb_pkg::*;

	// CJK code point ranges.
	localparam logic [20:0] CJK_A_LO = 21'h03400;
	localparam logic [20:0] CJK_A_HI = 21'h04DBF;
	localparam logic [20:0] CJK_U_LO = 21'h04E00;
	localparam logic [20:0] CJK_U_HI = 21'h09FFF;
	localparam logic [20:0] CJK_C_LO = 21'h0F900;
	localparam logic [20:0] CJK_C_HI = 21'h0FAFF;

	// Outcome of scanning one byte against the held ASCII character.
	typedef struct packed {
		logic hv;
		logic [ASCII_W-1:0] hc;
		logic put;
		logic [ASCII_W-1:0] put_char;
		logic put_end;
	} scan_t;

	function automatic logic is_tok(input logic [BYTE_W-1:0] b);
		return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") ||
			(b >= "a" && b <= "z") || b == "_" || b == "+" || b == "#";
	endfunction

	function automatic logic [ASCII_W-1:0] to_lower(input logic [BYTE_W-1:0] b);
		if (b >= "A" && b <= "Z") begin
			return b[ASCII_W-1:0] + 7'd32;
		end
		return b[ASCII_W-1:0];
	endfunction

	function automatic logic [2:0] lead_len(input logic [BYTE_W-1:0] b);
		if (b[7] == 1'b0) return 3'd1;
		if (b[7:5] == 3'b110) return 3'd2;
		if (b[7:4] == 4'b1110) return 3'd3;
		if (b[7:3] == 5'b11110) return 3'd4;
		return 3'd1;
	endfunction

	function automatic logic is_cjk(input logic [20:0] cp);
		return (cp >= CJK_A_LO && cp <= CJK_A_HI) ||
			(cp >= CJK_U_LO && cp <= CJK_U_HI) ||
			(cp >= CJK_C_LO && cp <= CJK_C_HI);
	endfunction

	// A token byte extends the held token; anything else ends it.
	function automatic scan_t scan_byte(input logic [BYTE_W-1:0] b, input logic hv,
		input logic [ASCII_W-1:0] hc);
		scan_t s;
		s.put = hv;
		s.put_char = hc;
		if (b[7] == 1'b0 && is_tok(b)) begin
			s.put_end = 1'b0;
			s.hv = 1'b1;
			s.hc = to_lower(b);
		end else begin
			s.put_end = 1'b1;
			s.hv = 1'b0;
			s.hc = '0;
		end
		return s;
	endfunction

	logic held_valid_q, held_valid_d;
	logic [ASCII_W-1:0] held_char_q, held_char_d;
	logic [2:0] seq_len_q, seq_len_d;
	logic [1:0] seq_got_q, seq_got_d;
	logic [20:0] seq_value_q, seq_value_d;
	logic [BYTE_W-1:0] seq_lead_q, seq_lead_d;
	logic seq_broken_q, seq_broken_d;
	logic [BYTE_W-1:0] seq_tail_q [3];
	logic [CNT_W-1:0] run_count_q, run_count_d;
	logic tail_we;
	logic accept;

	assign accept = text_ch.valid && take_ok;
	assign text_ch.ready = take_ok;

	// Next state, work for the sequencer and run memory write for one item.
	always_comb begin
		logic [BYTE_W-1:0] b;
		logic [2:0] got_n;
		logic [20:0] val_n;
		logic brk_n;
		logic [20:0] cp;
		logic [CNT_W-1:0] cnt_inc;
		logic skip1;
		logic [2:0] ln;
		scan_t s0;
		scan_t s1;
		scan_t sn;

		b = text_ch.text_byte;
		got_n = {1'b0, seq_got_q} + 3'd1;
		val_n = seq_value_q;
		brk_n = seq_broken_q;
		cp = '0;
		cnt_inc = run_count_q + CNT_W'(1);
		skip1 = 1'b0;
		ln = lead_len(b);
		s0 = '0;
		s1 = '0;
		sn = '0;

		held_valid_d = held_valid_q;
		held_char_d = held_char_q;
		seq_len_d = seq_len_q;
		seq_got_d = seq_got_q;
		seq_value_d = seq_value_q;
		seq_lead_d = seq_lead_q;
		seq_broken_d = seq_broken_q;
		run_count_d = run_count_q;
		tail_we = 1'b0;
		run_wr = '0;
		job = '0;
		job.start = accept;

		if (text_ch.command == CMD_END) begin
			// End of text: flush the run, rescan an unfinished sequence, reset.
			job.run_n = run_count_q;
			if (seq_len_q != 3'd0) begin
				if (seq_got_q >= 2'd1) begin
					s0 = scan_byte(seq_tail_q[0], 1'b0, '0);
					skip1 = seq_tail_q[0][7] && (lead_len(seq_tail_q[0]) == 3'd2) &&
						(seq_got_q == 2'd2);
				end
				if (seq_got_q == 2'd2 && !skip1) begin
					s1 = scan_byte(seq_tail_q[1], s0.hv, s0.hc);
				end else begin
					s1 = s0;
					s1.put = 1'b0;
				end
				if (s1.put) begin
					job.d_char[0] = s1.put_char;
					job.d_end[0] = s1.put_end;
					job.d_cnt = 2'd1;
				end
				if (s1.hv) begin
					job.d_char[job.d_cnt[0]] = s1.hc;
					job.d_end[job.d_cnt[0]] = 1'b1;
					job.d_cnt = job.d_cnt + 2'd1;
				end
			end else if (held_valid_q) begin
				job.d_char[0] = held_char_q;
				job.d_end[0] = 1'b1;
				job.d_cnt = 2'd1;
			end
			held_valid_d = 1'b0;
			held_char_d = '0;
			seq_len_d = '0;
			seq_got_d = '0;
			seq_value_d = '0;
			seq_lead_d = '0;
			seq_broken_d = 1'b0;
			run_count_d = '0;
		end else if (seq_len_q != 3'd0) begin
			// Byte inside an open sequence: every byte counts toward its length.
			tail_we = 1'b1;
			if (b[7:6] != 2'b10) begin
				brk_n = 1'b1;
			end else begin
				val_n = {seq_value_q[14:0], b[5:0]};
			end
			if (got_n + 3'd1 >= seq_len_q) begin
				cp = brk_n ? {13'd0, seq_lead_q} : val_n;
				if (is_cjk(cp)) begin
					run_wr.en = accept;
					run_wr.addr = run_count_q[RUN_AW-1:0];
					run_wr.data = cp[CODE_W-1:0];
					if (cnt_inc >= CNT_W'(MAX_RUN)) begin
						job.run_n = cnt_inc;
						run_count_d = '0;
					end else begin
						run_count_d = cnt_inc;
					end
				end else begin
					job.run_n = run_count_q;
					run_count_d = '0;
				end
				seq_len_d = '0;
				seq_got_d = '0;
				seq_value_d = '0;
				seq_lead_d = '0;
				seq_broken_d = 1'b0;
			end else begin
				seq_got_d = got_n[1:0];
				seq_value_d = val_n;
				seq_broken_d = brk_n;
			end
		end else begin
			// Byte outside a sequence: ASCII, stray byte or lead byte.
			sn = scan_byte(b, held_valid_q, held_char_q);
			if (sn.put) begin
				job.d_char[0] = sn.put_char;
				job.d_end[0] = sn.put_end;
				job.d_cnt = 2'd1;
			end
			held_valid_d = sn.hv;
			held_char_d = sn.hc;
			if (b[7] == 1'b0 || ln == 3'd1) begin
				job.run_n = run_count_q;
				run_count_d = '0;
			end else begin
				seq_len_d = ln;
				seq_got_d = '0;
				seq_lead_d = b;
				seq_broken_d = 1'b0;
				unique case (ln)
					3'd2: seq_value_d = {16'd0, b[4:0]};
					3'd3: seq_value_d = {17'd0, b[3:0]};
					default: seq_value_d = {18'd0, b[2:0]};
				endcase
			end
		end
	end

	// Control and sequence state, updated once per accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			held_char_q <= '0;
			seq_len_q <= '0;
			seq_got_q <= '0;
			seq_value_q <= '0;
			seq_lead_q <= '0;
			seq_broken_q <= 1'b0;
			run_count_q <= '0;
		end else if (accept) begin
			held_valid_q <= held_valid_d;
			held_char_q <= held_char_d;
			seq_len_q <= seq_len_d;
			seq_got_q <= seq_got_d;
			seq_value_q <= seq_value_d;
			seq_lead_q <= seq_lead_d;
			seq_broken_q <= seq_broken_d;
			run_count_q <= run_count_d;
		end
	end

	// Trailing bytes of the open sequence, kept for the end-of-text rescan.
	always_ff @(posedge clk) begin
		if (accept && tail_we && seq_got_q != 2'd3) begin
			seq_tail_q[seq_got_q] <= text_ch.text_byte;
		end
	end

	a_seq_room: assert property (@(posedge clk) disable iff (!arst_n)
		seq_len_q != 3'd0 |-> ({1'b0, seq_got_q} + 3'd1 < seq_len_q))
		else $error("open sequence holds more bytes than its length");

	a_run_below_max: assert property (@(posedge clk) disable iff (!arst_n)
		run_count_q < CNT_W'(MAX_RUN))
		else $error("buffered run reached the flush length without a flush");

	a_held_outside_seq: assert property (@(posedge clk) disable iff (!arst_n)
		held_valid_q |-> seq_len_q == 3'd0)
		else $error("held ASCII character survived a lead byte");

endmodule

FILE: hdl/cjkb_emit.sv
// Result sequencer of the tokenizer: steps through the run memory for the
// single and pair tokens, then the ASCII results. Depends on cjkb_pkg, cjkb_ifs.
module cjkb_emit (
	input logic clk,
	input logic arst_n,
	input cjkb_pkg::job_t job,
	output logic take_ok,
	output logic [cjkb_pkg::RUN_AW-1:0] run_raddr,
	input logic [cjkb_pkg::CODE_W-1:0] run_rdata,
	cjkb_token_if.source token_ch
);
	import cjkb_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_SINGLE,
		PH_PAIR,
		PH_DIRECT
	} phase_t;

	phase_t phase_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] k_q;
	logic half_q;
	logic [1:0] d_cnt_q;
	logic [1:0][ASCII_W-1:0] d_char_q;
	logic [1:0] d_end_q;
	logic di_q;

	logic valid_s1;
	logic from_ram_s1;
	logic [RUN_AW-1:0] addr_s1;
	logic [ASCII_W-1:0] char_s1;
	logic end_s1;
	logic last_s1;

	logic out_valid_q;
	logic [CODE_W-1:0] code_q;
	logic end_q;
	logic last_q;

	logic g_ram;
	logic [RUN_AW-1:0] g_addr;
	logic [ASCII_W-1:0] g_char;
	logic g_end;
	logic g_last;
	logic gen_fire;
	logic s1_adv;
	phase_t after_run;

	assign s1_adv = valid_s1 && (!out_valid_q || token_ch.ready);
	assign gen_fire = (phase_q != PH_IDLE) && (!valid_s1 || s1_adv);
	assign take_ok = (phase_q == PH_IDLE) && !valid_s1;
	assign after_run = (d_cnt_q != 2'd0) ? PH_DIRECT : PH_IDLE;

	// A stalled first stage keeps re-reading its own address so the data holds.
	assign run_raddr = gen_fire ? g_addr : addr_s1;

	assign token_ch.valid = out_valid_q;
	assign token_ch.char_code = code_q;
	assign token_ch.token_end = end_q;
	assign token_ch.last = last_q;

	// Describe the result the sequencer issues in this cycle.
	always_comb begin
		g_ram = 1'b0;
		g_addr = '0;
		g_char = '0;
		g_end = 1'b0;
		g_last = 1'b0;
		unique case (phase_q)
			PH_SINGLE: begin
				g_ram = 1'b1;
				g_addr = k_q[RUN_AW-1:0];
				g_end = 1'b1;
				g_last = (k_q == n_q - CNT_W'(1)) && (n_q < CNT_W'(2)) &&
					(d_cnt_q == 2'd0);
			end
			PH_PAIR: begin
				g_ram = 1'b1;
				g_addr = k_q[RUN_AW-1:0] + RUN_AW'(half_q);
				g_end = half_q;
				g_last = half_q && (k_q == n_q - CNT_W'(2)) && (d_cnt_q == 2'd0);
			end
			PH_DIRECT: begin
				g_char = d_char_q[di_q];
				g_end = d_end_q[di_q];
				g_last = ({1'b0, di_q} + 2'd1) == d_cnt_q;
			end
			default: begin
				g_ram = 1'b0;
			end
		endcase
	end

	// Sequencer state, first stage and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			n_q <= '0;
			k_q <= '0;
			half_q <= 1'b0;
			d_cnt_q <= '0;
			d_char_q <= '0;
			d_end_q <= '0;
			di_q <= 1'b0;
			valid_s1 <= 1'b0;
			from_ram_s1 <= 1'b0;
			addr_s1 <= '0;
			char_s1 <= '0;
			end_s1 <= 1'b0;
			last_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			code_q <= '0;
			end_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			// Load new work, or step through the current one.
			if (take_ok && job.start) begin
				n_q <= job.run_n;
				d_cnt_q <= job.d_cnt;
				d_char_q <= job.d_char;
				d_end_q <= job.d_end;
				k_q <= '0;
				half_q <= 1'b0;
				di_q <= 1'b0;
				if (job.run_n != '0) begin
					phase_q <= PH_SINGLE;
				end else if (job.d_cnt != 2'd0) begin
					phase_q <= PH_DIRECT;
				end else begin
					phase_q <= PH_IDLE;
				end
			end else if (gen_fire) begin
				unique case (phase_q)
					PH_SINGLE: begin
						if (k_q == n_q - CNT_W'(1)) begin
							k_q <= '0;
							phase_q <= (n_q >= CNT_W'(2)) ? PH_PAIR : after_run;
						end else begin
							k_q <= k_q + CNT_W'(1);
						end
					end
					PH_PAIR: begin
						if (!half_q) begin
							half_q <= 1'b1;
						end else begin
							half_q <= 1'b0;
							if (k_q == n_q - CNT_W'(2)) begin
								phase_q <= after_run;
							end else begin
								k_q <= k_q + CNT_W'(1);
							end
						end
					end
					PH_DIRECT: begin
						di_q <= 1'b1;
						if (g_last) begin
							phase_q <= PH_IDLE;
						end
					end
					default: begin
						phase_q <= PH_IDLE;
					end
				endcase
			end

			// First stage: waits for the memory read of its address.
			if (gen_fire) begin
				valid_s1 <= 1'b1;
				from_ram_s1 <= g_ram;
				addr_s1 <= g_addr;
				char_s1 <= g_char;
				end_s1 <= g_end;
				last_s1 <= g_last;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end

			// Output register toward the receiver.
			if (s1_adv) begin
				out_valid_q <= 1'b1;
				code_q <= from_ram_s1 ? run_rdata : {{(CODE_W - ASCII_W){1'b0}}, char_s1};
				end_q <= end_s1;
				last_q <= last_s1;
			end else if (token_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_single_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SINGLE |-> k_q < n_q)
		else $error("single-token index ran past the run length");

	a_pair_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAIR |-> (n_q >= CNT_W'(2)) && (k_q <= n_q - CNT_W'(2)))
		else $error("pair index ran past the run length");

	a_ascii_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !from_ram_s1 |-> (phase_q == PH_DIRECT || phase_q == PH_IDLE))
		else $error("ASCII result issued while the run was still flushing");

endmodule

FILE: hdl/utf8_cjk_bigram_tokenizer.sv
// Top level of the UTF-8 CJK bigram tokenizer: byte decoder, run memory and
// result sequencer. Depends on cjkb_pkg, cjkb_ifs, cjkb_ram, cjkb_decode, cjkb_emit.
//
// Usage:
// - text_ch takes one item per handshake: a UTF-8 byte (command 0) or the end
//   of text (command 1), which flushes everything and returns to the reset state.
// - token_ch gives the token characters one per item: char_code, token_end on
//   the final character of each token, and last on the final result of an input.
// - Buffered CJK runs live in a 16-entry run memory; when a run ends, the
//   sequencer reads it back once per result for the single tokens, then the pairs.
// - The first result of an input is registered in the first stage, then in the
//   output register, before it is offered. An input that causes results holds
//   text_ch.ready low while the sequencer walks the run memory through its single
//   read port; an input with no result leaves it high. The next input may be
//   taken while the final result still waits in the output register.
// - A stalled receiver holds the output register and the sequencer; no result
//   is dropped or repeated.
// - Reset (arst_n low) clears the sequence state, the held character and the
//   run count at once; no clearing pass is needed.
module utf8_cjk_bigram_tokenizer (
	input logic clk,
	input logic arst_n,
	cjkb_text_if.sink text_ch,
	cjkb_token_if.source token_ch
);
	import cjkb_pkg::*;

	job_t job;
	run_wr_t run_wr;
	logic take_ok;
	logic [RUN_AW-1:0] run_raddr;
	logic [CODE_W-1:0] run_rdata;

	cjkb_decode u_decode (
		.clk (clk),
		.arst_n (arst_n),
		.text_ch (text_ch),
		.take_ok (take_ok),
		.job (job),
		.run_wr (run_wr)
	);

	cjkb_ram #(
		.Width (CODE_W),
		.Depth (RUN_DEPTH)
	) u_run_ram (
		.clk (clk),
		.we (run_wr.en),
		.waddr (run_wr.addr),
		.wdata (run_wr.data),
		.raddr (run_raddr),
		.rdata (run_rdata)
	);

	cjkb_emit u_emit (
		.clk (clk),
		.arst_n (arst_n),
		.job (job),
		.take_ok (take_ok),
		.run_raddr (run_raddr),
		.run_rdata (run_rdata),
		.token_ch (token_ch)
	);

endmodule

FILE: tb/tb_utf8_cjk_bigram_tokenizer.sv
`timescale 1ns / 100ps
// Self-checking testbench of the UTF-8 CJK bigram tokenizer: directed and random byte
// streams are scored against a built-in tokenizer model. Depends on cjkb_pkg,
// cjkb_ifs and the tokenizer RTL.
module tb_utf8_cjk_bigram_tokenizer;
	import cjkb_pkg::*;

	// One token character as the output channel carries it.
	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic tok_end;
		logic last;
	} token_char_t;

	logic clk;
	logic arst_n;
	int errors;
	int items_sent;
	bit tx_free;
	bit rx_free;

	// Token characters still owed by the block, oldest first.
	token_char_t token_q[$];
	// Token characters caused by the item being modeled.
	token_char_t item_q[$];

	// Tokenizer model state.
	logic [ASCII_W-1:0] held_char;
	logic held_valid;
	logic [2:0] seq_len;
	logic [1:0] seq_got;
	logic [20:0] seq_value;
	logic [BYTE_W-1:0] seq_lead;
	logic seq_broken;
	logic [BYTE_W-1:0] seq_tail [3];
	logic [CODE_W-1:0] run_mem [RUN_DEPTH];
	logic [CNT_W-1:0] run_len;

	cjkb_text_if text_ch ();
	cjkb_token_if token_ch ();

	utf8_cjk_bigram_tokenizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.text_ch(text_ch),
		.token_ch(token_ch)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog for a block that stops answering.
	initial begin
		#40_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Idle length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// ------------------------------------------------------------------
	// Tokenizer model
	// ------------------------------------------------------------------

	function automatic void emit(input logic [CODE_W-1:0] code, input logic tok_end);
		token_char_t t;
		t.code = code;
		t.tok_end = tok_end;
		t.last = 1'b0;
		item_q = {item_q, t};
	endfunction

	function automatic bit is_cjk(input logic [20:0] cp);
		return (cp >= 21'h3400 && cp <= 21'h4DBF) || (cp >= 21'h4E00 && cp <= 21'h9FFF) ||
			(cp >= 21'hF900 && cp <= 21'hFAFF);
	endfunction

	function automatic int seq_length(input logic [7:0] b);
		if (b[7] == 1'b0) return 1;
		if (b[7:5] == 3'b110) return 2;
		if (b[7:4] == 4'b1110) return 3;
		if (b[7:3] == 5'b11110) return 4;
		return 1;
	endfunction

	task automatic flush_held();
		if (held_valid) emit({{(CODE_W-ASCII_W){1'b0}}, held_char}, 1'b1);
		held_valid = 1'b0;
		held_char = '0;
	endtask

	// A finished run gives every character alone, then every adjacent pair.
	task automatic flush_cjk_run();
		int n;
		n = (run_len > MAX_RUN) ? MAX_RUN : int'(run_len);
		for (int k = 0; k < n; k++) emit(run_mem[k % RUN_DEPTH], 1'b1);
		for (int k = 0; k + 1 < n; k++) begin
			emit(run_mem[k % RUN_DEPTH], 1'b0);
			emit(run_mem[(k + 1) % RUN_DEPTH], 1'b1);
		end
		run_len = '0;
	endtask

	task automatic ascii_in(input logic [7:0] b);
		bit tok;
		bit upper;
		upper = (b >= "A" && b <= "Z");
		tok = (b >= "0" && b <= "9") || upper || (b >= "a" && b <= "z") ||
			b == "_" || b == "+" || b == "#";
		flush_cjk_run();
		if (tok) begin
			if (held_valid) emit({{(CODE_W-ASCII_W){1'b0}}, held_char}, 1'b0);
			held_char = upper ? ASCII_W'(b + 8'd32) : b[ASCII_W-1:0];
			held_valid = 1'b1;
		end else begin
			flush_held();
		end
	endtask

	task automatic add_cjk(input logic [CODE_W-1:0] cp);
		run_mem[run_len % RUN_DEPTH] = cp;
		run_len = run_len + 1'b1;
		if (run_len >= MAX_RUN) flush_cjk_run();
	endtask

	task automatic close_seq();
		seq_len = '0;
		seq_got = '0;
		seq_value = '0;
		seq_lead = '0;
		seq_broken = 1'b0;
	endtask

	task automatic byte_in(input logic [7:0] b);
		int n;
		logic [20:0] cp;
		if (seq_len != 0) begin
			// Every byte joins the open sequence; a bad one only marks it broken.
			if (seq_got < 3) seq_tail[seq_got] = b;
			if (b[7:6] != 2'b10) seq_broken = 1'b1;
			else seq_value = {seq_value[14:0], b[5:0]};
			seq_got = seq_got + 2'd1;
			if (int'(seq_got) + 1 >= int'(seq_len)) begin
				cp = seq_broken ? {13'b0, seq_lead} : seq_value;
				if (is_cjk(cp)) add_cjk(cp[CODE_W-1:0]);
				else flush_cjk_run();
				close_seq();
			end
		end else if (b[7] == 1'b0) begin
			ascii_in(b);
		end else begin
			flush_held();
			n = seq_length(b);
			if (n == 1) begin
				flush_cjk_run();
			end else begin
				seq_len = 3'(n);
				seq_got = '0;
				seq_lead = b;
				seq_broken = 1'b0;
				seq_value = 21'(b) & 21'((1 << (7 - n)) - 1);
			end
		end
	endtask

	// End of text dissolves an open sequence and rescans its tail bytes.
	task automatic end_in();
		int cnt;
		int i;
		int n;
		logic [7:0] b;
		if (seq_len != 0) begin
			cnt = seq_got;
			flush_held();
			flush_cjk_run();
			i = 0;
			while (i < cnt) begin
				b = seq_tail[i];
				if (b[7] == 1'b0) begin
					ascii_in(b);
					i++;
				end else begin
					n = seq_length(b);
					if (i + n > cnt) n = 1;
					flush_held();
					flush_cjk_run();
					i += n;
				end
			end
			close_seq();
		end
		flush_held();
		flush_cjk_run();
	endtask

	task automatic tokenize_item(input logic cmd, input logic [7:0] b);
		item_q.delete();
		if (cmd == CMD_END) end_in();
		else byte_in(b);
		if (item_q.size() > 0) item_q[item_q.size() - 1].last = 1'b1;
		token_q = {token_q, item_q};
	endtask

	// ------------------------------------------------------------------
	// Channel drivers and checker
	// ------------------------------------------------------------------

	// Send one item and model it once the handshake completes.
	task automatic send_item(input logic cmd, input logic [7:0] b);
		int gap;
		gap = tx_free ? 0 : pick_gap();
		repeat (gap) begin
			@(negedge clk);
			text_ch.valid <= 1'b0;
		end
		@(negedge clk);
		text_ch.valid <= 1'b1;
		text_ch.command <= cmd;
		text_ch.text_byte <= b;
		@(posedge clk);
		while (!text_ch.ready) @(posedge clk);
		tokenize_item(cmd, b);
		items_sent++;
	endtask

	// Hold the sender off until every owed token character has come out.
	task automatic wait_drain();
		@(negedge clk);
		text_ch.valid <= 1'b0;
		while (token_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Receiver: bursts of ready with stalls between them.
	initial begin : rx_pattern
		int burst;
		int gap;
		token_ch.ready = 1'b0;
		forever begin
			burst = $urandom_range(1, 24);
			repeat (burst) begin
				@(negedge clk);
				token_ch.ready <= 1'b1;
			end
			gap = rx_free ? 0 : pick_gap();
			repeat (gap) begin
				@(negedge clk);
				token_ch.ready <= 1'b0;
			end
		end
	end

	// Compare each accepted token character with the oldest one owed.
	always @(posedge clk) begin : check_tokens
		token_char_t want;
		if (arst_n && token_ch.valid && token_ch.ready) begin
			if (token_q.size() == 0) begin
				$display("%0t: unexpected item char_code %h token_end %b last %b", $time,
					token_ch.char_code, token_ch.token_end, token_ch.last);
				errors++;
			end else begin
				want = token_q.pop_front();
				if (token_ch.char_code !== want.code) begin
					$display("%0t: char_code expected %h actual %h", $time, want.code,
						token_ch.char_code);
					errors++;
				end
				if (token_ch.token_end !== want.tok_end) begin
					$display("%0t: token_end expected %b actual %b", $time, want.tok_end,
						token_ch.token_end);
					errors++;
				end
				if (token_ch.last !== want.last) begin
					$display("%0t: last expected %b actual %b", $time, want.last,
						token_ch.last);
					errors++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Encode a code point in len bytes; a short value in many bytes is overlong.
	task automatic send_utf8(input logic [20:0] cp, input int len);
		case (len)
			2: begin
				send_item(CMD_TEXT, {3'b110, cp[10:6]});
				send_item(CMD_TEXT, {2'b10, cp[5:0]});
			end
			3: begin
				send_item(CMD_TEXT, {4'b1110, cp[15:12]});
				send_item(CMD_TEXT, {2'b10, cp[11:6]});
				send_item(CMD_TEXT, {2'b10, cp[5:0]});
			end
			default: begin
				send_item(CMD_TEXT, {5'b11110, cp[20:18]});
				send_item(CMD_TEXT, {2'b10, cp[17:12]});
				send_item(CMD_TEXT, {2'b10, cp[11:6]});
				send_item(CMD_TEXT, {2'b10, cp[5:0]});
			end
		endcase
	endtask

	function automatic logic [20:0] rand_cjk();
		case ($urandom_range(0, 4))
			0: return 21'($urandom_range(16'h3400, 16'h4DBF));
			1: return 21'($urandom_range(16'h4E00, 16'h9FFF));
			2: return 21'($urandom_range(16'hF900, 16'hFAFF));
			3: return $urandom_range(0, 1) ? 21'h3400 : 21'h4DBF;
			default: begin
				case ($urandom_range(0, 3))
					0: return 21'h4E00;
					1: return 21'h9FFF;
					2: return 21'hF900;
					default: return 21'hFAFF;
				endcase
			end
		endcase
	endfunction

	// Three-byte code points outside the CJK ranges, boundaries included.
	function automatic logic [20:0] rand_non_cjk();
		case ($urandom_range(0, 3))
			0: return 21'($urandom_range(16'h0800, 16'h33FF));
			1: return 21'($urandom_range(16'h4DC0, 16'h4DFF));
			2: return 21'($urandom_range(16'hA000, 16'hF8FF));
			default: return 21'($urandom_range(16'hFB00, 16'hFFFF));
		endcase
	endfunction

	function automatic logic [7:0] make_lead(input int len);
		case (len)
			2: return {3'b110, 5'($urandom_range(0, 31))};
			3: return {4'b1110, 4'($urandom_range(0, 15))};
			default: return {5'b11110, 3'($urandom_range(0, 7))};
		endcase
	endfunction

	// Mostly continuation bytes, sometimes anything.
	function automatic logic [7:0] rand_tail();
		if ($urandom_range(0, 9) < 7) return {2'b10, 6'($urandom_range(0, 63))};
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] rand_token_char();
		case ($urandom_range(0, 4))
			0: return 8'("A" + $urandom_range(0, 25));
			1: return 8'("a" + $urandom_range(0, 25));
			2: return 8'("0" + $urandom_range(0, 9));
			default: begin
				case ($urandom_range(0, 2))
					0: return "_";
					1: return "+";
					default: return "#";
				endcase
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Token characters with case folding, then byte extremes as separators.
	task automatic test_ascii_tokens();
		string word;
		word = "aZ_#+9";
		for (int i = 0; i < word.len(); i++) send_item(CMD_TEXT, word[i]);
		send_item(CMD_TEXT, 8'h00);
		send_item(CMD_TEXT, "Q");
		send_item(CMD_TEXT, 8'h7F);
		send_item(CMD_END, 8'hFF);
	endtask

	// Range edges, a code point just past a range, and an overlong CJK form.
	task automatic test_cjk_ranges();
		send_utf8(21'h3400, 3);
		send_utf8(21'hFAFF, 3);
		send_utf8(21'h4DC0, 3);
		send_utf8(21'h3400, 4);
		send_item(CMD_END, 8'h00);
	endtask

	// A bad byte inside a sequence, then a stray byte with the top bit set.
	task automatic test_bad_sequences();
		send_item(CMD_TEXT, 8'hE4);
		send_item(CMD_TEXT, "A");
		send_item(CMD_TEXT, 8'h80);
		send_item(CMD_TEXT, 8'hFF);
		send_item(CMD_END, 8'h5A);
	endtask

	// End of text inside a sequence: a two-byte lead with its partner, then ASCII.
	task automatic test_end_open_sequence();
		send_item(CMD_TEXT, 8'hF0);
		send_item(CMD_TEXT, 8'hC3);
		send_item(CMD_TEXT, 8'hA9);
		send_item(CMD_END, 8'h00);
		send_item(CMD_TEXT, 8'hE4);
		send_item(CMD_TEXT, "a");
		send_item(CMD_END, 8'hA5);
	endtask

	// A run that overflows the buffer is flushed early and a new one starts.
	task automatic test_run_limit();
		repeat (MAX_RUN + 1) send_utf8(rand_cjk(), 3);
		send_item(CMD_END, 8'($urandom_range(0, 255)));
	endtask

	// Mostly well-formed text with random content, plus noise and broken forms.
	task automatic test_random(input int count);
		int stop;
		int r;
		int n;
		int len;
		stop = items_sent + count;
		while (items_sent < stop) begin
			r = $urandom_range(0, 99);
			if (r < 22) begin
				send_item(CMD_TEXT, rand_token_char());
			end else if (r < 32) begin
				send_item(CMD_TEXT, 8'($urandom_range(0, 127)));
			end else if (r < 56) begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 4);
				repeat (n) send_utf8(rand_cjk(), ($urandom_range(0, 15) == 0) ? 4 : 3);
			end else if (r < 64) begin
				case ($urandom_range(0, 2))
					0: send_utf8(21'($urandom_range(0, 11'h7FF)), 2);
					1: send_utf8(rand_non_cjk(), 3);
					default: send_utf8(21'($urandom_range(0, 21'h1FFFFF)), 4);
				endcase
			end else if (r < 72) begin
				len = $urandom_range(2, 4);
				send_item(CMD_TEXT, make_lead(len));
				repeat (len - 1) send_item(CMD_TEXT, rand_tail());
			end else if (r < 78) begin
				send_item(CMD_TEXT, $urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF)) :
					8'($urandom_range(8'hF8, 8'hFF)));
			end else if (r < 85) begin
				// Sequence cut short by the end of text.
				len = $urandom_range(2, 4);
				send_item(CMD_TEXT, make_lead(len));
				repeat ($urandom_range(0, len - 2))
					send_item(CMD_TEXT, $urandom_range(0, 1) ? rand_tail() :
						8'($urandom_range(0, 255)));
				send_item(CMD_END, 8'($urandom_range(0, 255)));
			end else if (r < 92) begin
				send_item(CMD_END, 8'($urandom_range(0, 255)));
			end else begin
				send_item(CMD_TEXT, 8'($urandom_range(0, 255)));
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin : main_seq
		arst_n = 1'b0;
		text_ch.valid = 1'b0;
		text_ch.command = CMD_TEXT;
		text_ch.text_byte = '0;
		tx_free = 1'b1;
		rx_free = 1'b1;
		errors = 0;
		items_sent = 0;
		held_char = '0;
		held_valid = 1'b0;
		run_len = '0;
		close_seq();

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed cases with both sides running freely.
		test_ascii_tokens();
		test_cjk_ranges();
		wait_drain();
		test_bad_sequences();
		test_end_open_sequence();

		// From here on both sides idle at random, except for one stretch.
		tx_free = 1'b0;
		rx_free = 1'b0;
		test_run_limit();
		test_random(160);
		wait_drain();
		tx_free = 1'b1;
		rx_free = 1'b1;
		test_random(60);
		tx_free = 1'b0;
		rx_free = 1'b0;
		test_random(160);
		send_item(CMD_END, 8'h00);

		wait_drain();
		repeat (16) @(posedge clk);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
